/* rtl/cfsg_pkg.sv */
// Shared constants and types for the filled-circle span generator.
package cfsg_pkg;

   // Default sizes of the radius and of the center coordinates.
   localparam int RADIUS_BITS_DEFAULT = 11;
   localparam int COORD_BITS_DEFAULT  = 16;

   // Fixed widths of the result coordinates, the color and the register port.
   localparam int OUT_BITS       = 17;
   localparam int COLOR_BITS     = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic signed [OUT_BITS-1:0] coord_out_type;
   typedef logic [COLOR_BITS-1:0]      color_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2,
      CSR_COLOR    = 2'd3
   } csr_index_type;

endpackage

/* rtl/cfsg_front.sv */
// Input stage: range check of the row offset and the radicand product.
module cfsg_front
   import cfsg_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [RADIUS_BITS-1:0]     in_row_offset,
   input  logic [RADIUS_BITS-1:0]     radius,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [2*RADIUS_BITS-1:0]   out_rem,
   output logic [RADIUS_BITS:0]       out_side
);

   localparam int PROD_BITS = 2 * RADIUS_BITS;

   logic                   valid_ff, valid_in;
   logic [PROD_BITS-1:0]   rem_ff, rem_in;
   logic [RADIUS_BITS:0]   side_ff, side_in;
   logic                   in_range;
   logic [RADIUS_BITS:0]   span_term;
   logic [PROD_BITS-1:0]   product;

   // The stage takes a new transaction when empty or when its content moves on.
   assign in_ready = !valid_ff || out_ready;

   // Radicand dy * (2R - dy); it is at most R squared when dy is in range.
   always_comb begin
      in_range  = (in_row_offset != '0) && (in_row_offset <= radius);
      span_term = {radius, 1'b0} - {1'b0, in_row_offset};
      product   = PROD_BITS'(in_row_offset) * PROD_BITS'(span_term);
      rem_in    = in_range ? product : '0;
      side_in   = {in_range, in_row_offset};
      valid_in  = in_ready ? in_valid : valid_ff;
   end

   // Valid bit with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers load whenever the stage can take data.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/cfsg_sqrt_stage.sv */
// One stage of the pipelined integer square root: settles one root bit.
module cfsg_sqrt_stage
   import cfsg_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT,
   parameter int STEP        = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [2*RADIUS_BITS-1:0]   in_rem,
   input  logic [RADIUS_BITS-1:0]     in_root,
   input  logic [RADIUS_BITS:0]       in_side,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [2*RADIUS_BITS-1:0]   out_rem,
   output logic [RADIUS_BITS-1:0]     out_root,
   output logic [RADIUS_BITS:0]       out_side
);

   localparam int PROD_BITS = 2 * RADIUS_BITS;

   logic                   valid_ff, valid_in;
   logic [PROD_BITS-1:0]   rem_ff, rem_in;
   logic [RADIUS_BITS-1:0] root_ff, root_in;
   logic [RADIUS_BITS:0]   side_ff;
   logic [PROD_BITS-1:0]   trial;
   logic                   fits;

   assign in_ready = !valid_ff || out_ready;

   // The remainder holds v - root^2. Setting this bit adds
   // root * 2^(STEP+1) + 2^(2*STEP) to the square; the root has no bits
   // at or below STEP yet, so the two terms do not overlap.
   always_comb begin
      trial   = (PROD_BITS'(in_root) << (STEP + 1)) | (PROD_BITS'(1) << (2 * STEP));
      fits    = in_rem >= trial;
      rem_in  = fits ? (in_rem - trial) : in_rem;
      root_in = fits ? (in_root | (RADIUS_BITS'(1) << STEP)) : in_root;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   // Valid bit with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/cfsg_back.sv */
// Output stage: span end points, mirrored rows and the result register.
module cfsg_back
   import cfsg_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT,
   parameter int COORD_BITS  = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [RADIUS_BITS-1:0]        in_root,
   input  logic [RADIUS_BITS:0]          in_side,
   input  logic signed [COORD_BITS-1:0]  center_x,
   input  logic signed [COORD_BITS-1:0]  center_y,
   input  logic [RADIUS_BITS-1:0]        radius,
   input  color_type                     fill_color,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_span_valid,
   output coord_out_type                 rsp_x_left,
   output coord_out_type                 rsp_x_right,
   output coord_out_type                 rsp_y_upper,
   output coord_out_type                 rsp_y_lower,
   output color_type                     rsp_span_color
);

   localparam int WIDE_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
   localparam int CALC_BITS = (WIDE_BITS > OUT_BITS) ? WIDE_BITS : OUT_BITS;

   logic                  valid_ff, valid_in;
   logic                  span_ff;
   coord_out_type         x_left_ff, x_right_ff, y_upper_ff, y_lower_ff;
   color_type             color_ff;
   logic                  in_range;
   logic [CALC_BITS-1:0]  cx_wide, cy_wide, dx_wide, dy_wide, r_wide;
   logic [CALC_BITS-1:0]  x_left_wide, x_right_wide, y_upper_wide, y_lower_wide;

   assign in_ready = !valid_ff || rsp_ready;

   // Sign-extend the center, zero-extend the magnitudes, and wrap to the output width.
   always_comb begin
      in_range     = in_side[RADIUS_BITS];
      cx_wide      = {{(CALC_BITS-COORD_BITS){center_x[COORD_BITS-1]}}, center_x};
      cy_wide      = {{(CALC_BITS-COORD_BITS){center_y[COORD_BITS-1]}}, center_y};
      dx_wide      = {{(CALC_BITS-RADIUS_BITS){1'b0}}, in_root};
      dy_wide      = {{(CALC_BITS-RADIUS_BITS){1'b0}}, in_side[RADIUS_BITS-1:0]};
      r_wide       = {{(CALC_BITS-RADIUS_BITS){1'b0}}, radius};
      x_left_wide  = cx_wide - dx_wide;
      x_right_wide = cx_wide + dx_wide;
      y_upper_wide = cy_wide + dy_wide - r_wide;
      y_lower_wide = cy_wide - dy_wide + r_wide;
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   // Valid bit with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result register; an out-of-range row gives all-zero fields.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         span_ff    <= in_range;
         x_left_ff  <= in_range ? x_left_wide[OUT_BITS-1:0]  : '0;
         x_right_ff <= in_range ? x_right_wide[OUT_BITS-1:0] : '0;
         y_upper_ff <= in_range ? y_upper_wide[OUT_BITS-1:0] : '0;
         y_lower_ff <= in_range ? y_lower_wide[OUT_BITS-1:0] : '0;
         color_ff   <= in_range ? fill_color : '0;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_span_valid = span_ff;
   assign rsp_x_left     = x_left_ff;
   assign rsp_x_right    = x_right_ff;
   assign rsp_y_upper    = y_upper_ff;
   assign rsp_y_lower    = y_lower_ff;
   assign rsp_span_color = color_ff;

endmodule

/* rtl/circle_fill_span_generator.sv */
// Filled-circle span generator: configuration registers and the stage chain.
//
// Program the center, radius and fill color through the csr_ write port
// while no transaction is in flight. Each request transaction carries one
// row offset dy; each response transaction returns the span
// center_x -/+ floor(sqrt(dy * (2R - dy))), the two mirrored rows, the color
// and span_valid, which is low (all fields zero) when dy is 0 or above R.
// Both channels are valid/ready; one response comes back per request, in order.
// Each request passes in order through registered stages: the range check
// and radicand product, the square root chain, which settles the root bits
// most significant first, and the output adders and result register.
// A new request is taken every cycle while responses are taken.
// Every stage holds its own valid bit and moves when the next one is empty
// or moving, so a stalled receiver fills the chain up from the output
// register back; nothing is dropped or repeated, and empty stages still
// take requests. Synchronous reset empties all stages and clears the
// configuration registers to zero.
module circle_fill_span_generator
   import cfsg_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT,
   parameter int COORD_BITS  = COORD_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [RADIUS_BITS-1:0]     req_row_offset,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_span_valid,
   output coord_out_type              rsp_x_left,
   output coord_out_type              rsp_x_right,
   output coord_out_type              rsp_y_upper,
   output coord_out_type              rsp_y_lower,
   output color_type                  rsp_span_color
);

   localparam int PROD_BITS = 2 * RADIUS_BITS;

   logic signed [COORD_BITS-1:0] center_x_ff, center_y_ff;
   logic [RADIUS_BITS-1:0]       radius_ff;
   color_type                    color_ff;

   logic [RADIUS_BITS:0]         chain_valid;
   logic [RADIUS_BITS:0]         chain_ready;
   logic [PROD_BITS-1:0]         chain_rem  [RADIUS_BITS+1];
   logic [RADIUS_BITS-1:0]       chain_root [RADIUS_BITS+1];
   logic [RADIUS_BITS:0]         chain_side [RADIUS_BITS+1];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
         color_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X: center_x_ff <= csr_write_data[COORD_BITS-1:0];
            CSR_CENTER_Y: center_y_ff <= csr_write_data[COORD_BITS-1:0];
            CSR_RADIUS:   radius_ff   <= csr_write_data[RADIUS_BITS-1:0];
            CSR_COLOR:    color_ff    <= csr_write_data[COLOR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Range check and radicand.
   cfsg_front #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_row_offset (req_row_offset),
      .radius        (radius_ff),
      .out_valid     (chain_valid[0]),
      .out_ready     (chain_ready[0]),
      .out_rem       (chain_rem[0]),
      .out_side      (chain_side[0])
   );

   assign chain_root[0] = '0;

   // Square root chain, most significant root bit first.
   for (genvar k = 0; k < RADIUS_BITS; k++) begin : g_sqrt
      cfsg_sqrt_stage #(
         .RADIUS_BITS(RADIUS_BITS),
         .STEP       (RADIUS_BITS - 1 - k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_rem    (chain_rem[k]),
         .in_root   (chain_root[k]),
         .in_side   (chain_side[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_rem   (chain_rem[k+1]),
         .out_root  (chain_root[k+1]),
         .out_side  (chain_side[k+1])
      );
   end

   // Span end points and result register.
   cfsg_back #(
      .RADIUS_BITS(RADIUS_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (chain_valid[RADIUS_BITS]),
      .in_ready       (chain_ready[RADIUS_BITS]),
      .in_root        (chain_root[RADIUS_BITS]),
      .in_side        (chain_side[RADIUS_BITS]),
      .center_x       (center_x_ff),
      .center_y       (center_y_ff),
      .radius         (radius_ff),
      .fill_color     (color_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_span_valid (rsp_span_valid),
      .rsp_x_left     (rsp_x_left),
      .rsp_x_right    (rsp_x_right),
      .rsp_y_upper    (rsp_y_upper),
      .rsp_y_lower    (rsp_y_lower),
      .rsp_span_color (rsp_span_color)
   );

endmodule

/* rtl/cfsg_checker.sv */
// Port-level checks of the span generator and the bind that attaches them.
module cfsg_checker
   import cfsg_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic          rsp_span_valid,
   input coord_out_type rsp_x_left,
   input coord_out_type rsp_x_right,
   input coord_out_type rsp_y_upper,
   input coord_out_type rsp_y_lower,
   input color_type     rsp_span_color
);

   // A stalled response transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span_valid)
         && $stable(rsp_x_left) && $stable(rsp_x_right) && $stable(rsp_y_upper)
         && $stable(rsp_y_lower) && $stable(rsp_span_color))
   else $error("stalled response changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("response valid right after reset");

   // A row outside the circle carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |-> rsp_x_left == '0 && rsp_x_right == '0
         && rsp_y_upper == '0 && rsp_y_lower == '0 && rsp_span_color == '0)
   else $error("invalid span with nonzero fields");

   // The span and the mirrored rows are symmetric about the center, so the
   // two ends of each pair share their lowest bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_valid |-> rsp_x_left[0] == rsp_x_right[0]
         && rsp_y_upper[0] == rsp_y_lower[0])
   else $error("span ends not symmetric about the center");

endmodule

bind circle_fill_span_generator cfsg_checker u_cfsg_checker (.*);
